[sv/scrc_pkg.sv]
// scrc_pkg: shared types, character codes and verdict codes for the
// shell quote and redirect checker. no dependencies.

package scrc_pkg;

	// character codes
	localparam logic [7:0] CH_END    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_MORE   = 8'h3E;

	localparam int BYTE_W    = 8;
	localparam int VERDICT_W = 2;
	localparam int OUT_TDATA_W = 8;

	// verdict codes
	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_VALID    = 2'd0,
		VERDICT_QUOTE    = 2'd1,
		VERDICT_REDIRECT = 2'd2
	} verdict_t;

	// pending redirect kind
	typedef enum logic [1:0] {
		REDIR_NONE = 2'd0,
		REDIR_LESS = 2'd1,
		REDIR_MORE = 2'd2
	} redir_t;

	// line scan state
	typedef struct packed {
		logic       single_open;
		logic       double_open;
		redir_t     previous_redirect;
		logic [1:0] redirect_run;
		logic       space_after_redirect;
		logic       redirect_fault;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		single_open:          1'b0,
		double_open:          1'b0,
		previous_redirect:    REDIR_NONE,
		redirect_run:         2'd0,
		space_after_redirect: 1'b0,
		redirect_fault:       1'b0
	};

	// result of one step of the scanner
	typedef struct packed {
		logic     line_end;
		verdict_t verdict;
	} step_result_t;

endpackage

[sv/scrc_core.sv]
// scrc_core: line scan state registers and the per-byte update logic.
// depends on scrc_pkg.

module scrc_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               text_byte,
	output scrc_pkg::step_result_t   result
);

	scrc_pkg::scan_state_t state_q;
	scrc_pkg::scan_state_t state_d;
	scrc_pkg::redir_t      kind;
	logic                  any_quote;
	logic                  pending;

	assign any_quote = state_q.single_open | state_q.double_open;
	assign pending   = (state_q.previous_redirect != scrc_pkg::REDIR_NONE);
	assign kind      = (text_byte == scrc_pkg::CH_LESS) ? scrc_pkg::REDIR_LESS
	                                                    : scrc_pkg::REDIR_MORE;

	// verdict for an end byte, quote takes priority
	always_comb begin
		result.line_end = (text_byte == scrc_pkg::CH_END);
		if (any_quote) begin
			result.verdict = scrc_pkg::VERDICT_QUOTE;
		end else if (state_q.redirect_fault | pending) begin
			result.verdict = scrc_pkg::VERDICT_REDIRECT;
		end else begin
			result.verdict = scrc_pkg::VERDICT_VALID;
		end
	end

	// next scan state
	always_comb begin
		state_d = state_q;
		if (text_byte == scrc_pkg::CH_END) begin
			state_d = scrc_pkg::SCAN_RESET;
		end else if (text_byte == scrc_pkg::CH_SQUOTE && !state_q.double_open) begin
			state_d.single_open          = ~state_q.single_open;
			state_d.previous_redirect    = scrc_pkg::REDIR_NONE;
			state_d.redirect_run         = 2'd0;
			state_d.space_after_redirect = 1'b0;
		end else if (text_byte == scrc_pkg::CH_DQUOTE && !state_q.single_open) begin
			state_d.double_open          = ~state_q.double_open;
			state_d.previous_redirect    = scrc_pkg::REDIR_NONE;
			state_d.redirect_run         = 2'd0;
			state_d.space_after_redirect = 1'b0;
		end else if (any_quote) begin
			// literal text inside quotes
			state_d.previous_redirect    = scrc_pkg::REDIR_NONE;
			state_d.redirect_run         = 2'd0;
			state_d.space_after_redirect = 1'b0;
		end else if (text_byte == scrc_pkg::CH_LESS || text_byte == scrc_pkg::CH_MORE) begin
			if (pending && state_q.space_after_redirect) begin
				state_d.redirect_fault = 1'b1;
				state_d.redirect_run   = 2'd1;
			end else if (state_q.previous_redirect == kind) begin
				// run of equal redirects, saturating at three
				if (state_q.redirect_run != 2'd3) begin
					state_d.redirect_run = state_q.redirect_run + 2'd1;
				end
				if (state_q.redirect_run >= 2'd2) begin
					state_d.redirect_fault = 1'b1;
				end
			end else begin
				state_d.redirect_run = 2'd1;
			end
			state_d.previous_redirect    = kind;
			state_d.space_after_redirect = 1'b0;
		end else if (text_byte == scrc_pkg::CH_SPACE) begin
			if (pending) begin
				state_d.space_after_redirect = 1'b1;
				state_d.redirect_run         = 2'd0;
			end
		end else begin
			state_d.previous_redirect    = scrc_pkg::REDIR_NONE;
			state_d.redirect_run         = 2'd0;
			state_d.space_after_redirect = 1'b0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scrc_pkg::SCAN_RESET;
		end else if (step) begin
			state_q <= state_d;
		end
	end

endmodule

[sv/shell_quote_redirect_checker.sv]
// shell_quote_redirect_checker: top level, input register, scan core and
// verdict output register. depends on scrc_pkg and scrc_core.
// path: an end byte's verdict passes the input register and then the verdict register before m_tvalid offers it.
// throughput: one byte per cycle; only an end byte waits on a full output register.
// reset: arst_n clears the scan state and both valid flags at once.

module shell_quote_redirect_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   advance_s1;
	scrc_pkg::step_result_t result;
	scrc_pkg::verdict_t     verdict_q;
	logic                   out_valid_q;

	// stage one moves unless an end byte meets a held verdict
	assign advance_s1 = valid_s1 & (~result.line_end | ~out_valid_q | m_tready);
	assign s_tready   = ~valid_s1 | advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	scrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.text_byte (byte_s1),
		.result    (result)
	);

	// verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && result.line_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && result.line_end) begin
			verdict_q <= result.verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(scrc_pkg::OUT_TDATA_W - scrc_pkg::VERDICT_W){1'b0}}, verdict_q};

	// an end byte leaving stage one always lands in the verdict register
	a_end_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && result.line_end |=> out_valid_q)
		else $error("end byte lost its verdict");

	// input stalls only while stage one holds an item
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("input stalled with empty stage");

	// a held verdict never gets overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !(advance_s1 && result.line_end))
		else $error("verdict overwritten while stalled");

	// verdict code stays in range
	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> verdict_q != 2'd3)
		else $error("verdict code out of range");

endmodule

[dv/tb_shell_quote_redirect_checker.sv]
// tb_shell_quote_redirect_checker: self-checking testbench for the shell quote and
// redirect checker; directed lines from a table, then random token-built lines.
// depends on scrc_pkg and the shell_quote_redirect_checker rtl.

module tb_shell_quote_redirect_checker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 4;
	localparam int BYTE_TARGET  = 1150;
	localparam int QUIET_FROM   = 1000;
	localparam int HOLD_AT      = 300;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;
	localparam int DIRECTED_N   = 26;

	typedef struct {
		logic [scrc_pkg::BYTE_W-1:0] ch;
		bit                          typed;
		scrc_pkg::verdict_t          verdict;
	} stim_row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [scrc_pkg::BYTE_W-1:0]      s_tdata;   // [7:0] text_byte
	logic                             m_tvalid;
	logic                             m_tready;
	logic [scrc_pkg::OUT_TDATA_W-1:0] m_tdata;   // [1:0] verdict, [7:2] zero

	// verdict typed into the table for the byte now offered
	bit                 row_typed;
	scrc_pkg::verdict_t row_verdict;

	scrc_pkg::scan_state_t       line_scan;
	scrc_pkg::verdict_t          expected_verdicts[$];
	logic [scrc_pkg::BYTE_W-1:0] line_buf[$];
	stim_row_t                   directed_rows[DIRECTED_N];

	int  bytes_sent;
	int  fail_count;
	int  cycle_count;
	bit  quiet;
	bit  hold_done;
	int  tx_odds;

	shell_quote_redirect_checker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// run limit
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding",
				cycle_count, expected_verdicts.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// scan one byte of the line; on the end byte give the line verdict
	task automatic scan_byte(input logic [scrc_pkg::BYTE_W-1:0] ch, output bit line_done,
			output scrc_pkg::verdict_t verdict);
		scrc_pkg::redir_t kind;
		bit               fault;
		bit               pend;
		line_done = 1'b0;
		verdict   = scrc_pkg::VERDICT_VALID;
		pend      = (line_scan.previous_redirect != scrc_pkg::REDIR_NONE);
		if (ch == scrc_pkg::CH_END) begin
			line_done = 1'b1;
			fault = line_scan.redirect_fault || pend;
			if (line_scan.single_open || line_scan.double_open)
				verdict = scrc_pkg::VERDICT_QUOTE;
			else if (fault)
				verdict = scrc_pkg::VERDICT_REDIRECT;
			line_scan = scrc_pkg::SCAN_RESET;
		end else if ((ch == scrc_pkg::CH_SQUOTE && !line_scan.double_open) ||
				(ch == scrc_pkg::CH_DQUOTE && !line_scan.single_open)) begin
			if (ch == scrc_pkg::CH_SQUOTE)
				line_scan.single_open = ~line_scan.single_open;
			else
				line_scan.double_open = ~line_scan.double_open;
			line_scan.previous_redirect    = scrc_pkg::REDIR_NONE;
			line_scan.redirect_run         = 2'd0;
			line_scan.space_after_redirect = 1'b0;
		end else if (line_scan.single_open || line_scan.double_open) begin
			// literal text inside a quoted span
			line_scan.previous_redirect    = scrc_pkg::REDIR_NONE;
			line_scan.redirect_run         = 2'd0;
			line_scan.space_after_redirect = 1'b0;
		end else if (ch == scrc_pkg::CH_LESS || ch == scrc_pkg::CH_MORE) begin
			kind = (ch == scrc_pkg::CH_LESS) ? scrc_pkg::REDIR_LESS : scrc_pkg::REDIR_MORE;
			if (pend && line_scan.space_after_redirect) begin
				line_scan.redirect_fault = 1'b1;
				line_scan.redirect_run   = 2'd1;
			end else if (line_scan.previous_redirect == kind) begin
				if (line_scan.redirect_run < 2'd3)
					line_scan.redirect_run = line_scan.redirect_run + 2'd1;
				if (line_scan.redirect_run == 2'd3)
					line_scan.redirect_fault = 1'b1;
			end else begin
				line_scan.redirect_run = 2'd1;
			end
			line_scan.previous_redirect    = kind;
			line_scan.space_after_redirect = 1'b0;
		end else if (ch == scrc_pkg::CH_SPACE) begin
			if (pend) begin
				line_scan.space_after_redirect = 1'b1;
				line_scan.redirect_run         = 2'd0;
			end
		end else begin
			line_scan.previous_redirect    = scrc_pkg::REDIR_NONE;
			line_scan.redirect_run         = 2'd0;
			line_scan.space_after_redirect = 1'b0;
		end
	endtask

	// predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin : beat_monitor
		bit                 line_done;
		scrc_pkg::verdict_t predicted;
		scrc_pkg::verdict_t wanted;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata, line_done, predicted);
				if (line_done)
					expected_verdicts.push_back(row_typed ? row_verdict : predicted);
			end
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("unexpected verdict beat, tdata %h", m_tdata);
				end else begin
					wanted = expected_verdicts.pop_front();
					if (m_tdata[scrc_pkg::VERDICT_W-1:0] !== wanted ||
							m_tdata[scrc_pkg::OUT_TDATA_W-1:scrc_pkg::VERDICT_W] !== '0) begin
						fail_count++;
						if (fail_count <= REPORT_MAX)
							$display("verdict mismatch: expected %0d pad 0, got %0d pad %h",
								wanted, m_tdata[scrc_pkg::VERDICT_W-1:0],
								m_tdata[scrc_pkg::OUT_TDATA_W-1:scrc_pkg::VERDICT_W]);
					end
				end
			end
		end
	end

	// offer one byte, wait for its beat, return at the following falling edge
	task automatic send_byte(input logic [scrc_pkg::BYTE_W-1:0] ch, input bit typed,
			input scrc_pkg::verdict_t v);
		int gap;
		if (!quiet && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 16);
			repeat (gap) @(negedge clk);
		end
		s_tvalid    <= 1'b1;
		s_tdata     <= ch;
		row_typed   <= typed;
		row_verdict <= v;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		if (bytes_sent >= QUIET_FROM)
			quiet = 1'b1;
		@(negedge clk);
	endtask

	function automatic logic [scrc_pkg::BYTE_W-1:0] letter();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	// build one random line from tokens, ending with the end byte
	task automatic build_line();
		int                          tokens;
		int                          kind;
		int                          n;
		int                          pick;
		logic [scrc_pkg::BYTE_W-1:0] q;
		logic [scrc_pkg::BYTE_W-1:0] other;
		line_buf.delete();
		tokens = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
		repeat (tokens) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				// word
				n = $urandom_range(1, 4);
				repeat (n) line_buf.push_back(letter());
			end else if (kind < 45) begin
				// spaces
				n = $urandom_range(1, 2);
				repeat (n) line_buf.push_back(scrc_pkg::CH_SPACE);
			end else if (kind < 70) begin
				// redirect run, now and then switching kind
				q = $urandom_range(0, 1) ? scrc_pkg::CH_LESS : scrc_pkg::CH_MORE;
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 4) : $urandom_range(1, 2);
				repeat (n) begin
					line_buf.push_back(q);
					if ($urandom_range(0, 4) == 0)
						q = (q == scrc_pkg::CH_LESS) ? scrc_pkg::CH_MORE : scrc_pkg::CH_LESS;
				end
			end else if (kind < 85) begin
				// quoted span, mostly closed
				q     = $urandom_range(0, 1) ? scrc_pkg::CH_SQUOTE : scrc_pkg::CH_DQUOTE;
				other = (q == scrc_pkg::CH_SQUOTE) ? scrc_pkg::CH_DQUOTE : scrc_pkg::CH_SQUOTE;
				line_buf.push_back(q);
				n = $urandom_range(0, 4);
				repeat (n) begin
					pick = $urandom_range(0, 4);
					case (pick)
						0: line_buf.push_back(letter());
						1: line_buf.push_back(scrc_pkg::CH_LESS);
						2: line_buf.push_back(scrc_pkg::CH_MORE);
						3: line_buf.push_back(scrc_pkg::CH_SPACE);
						default: line_buf.push_back(other);
					endcase
				end
				if ($urandom_range(0, 9) != 0)
					line_buf.push_back(q);
			end else if (kind < 93) begin
				// any non-end byte
				line_buf.push_back(8'($urandom_range(1, 255)));
			end else begin
				// stray quote
				line_buf.push_back($urandom_range(0, 1) ? scrc_pkg::CH_SQUOTE
				                                        : scrc_pkg::CH_DQUOTE);
			end
		end
		line_buf.push_back(scrc_pkg::CH_END);
	endtask

	// receiver: random stalls, one long hold-off, none near the end
	initial begin : rx_side
		int burst;
		int odds;
		int span;
		m_tready = 1'b0;
		odds     = 0;
		span     = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (span == 0) begin
				span = $urandom_range(20, 80);
				odds = $urandom_range(0, 2) * 4;
			end
			span--;
			if (!hold_done && bytes_sent >= HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				m_tready  <= 1'b1;
				hold_done = 1'b1;
			end else if (!quiet && odds != 0 && $urandom_range(1, odds) == 1) begin
				m_tready <= 1'b0;
				burst = $urandom_range(1, 16);
				repeat (burst) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// sender: reset, directed table, random lines, drain
	initial begin : tx_side
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		row_typed   = 1'b0;
		row_verdict = scrc_pkg::VERDICT_VALID;
		arst_n      = 1'b0;
		line_scan   = scrc_pkg::SCAN_RESET;
		bytes_sent  = 0;
		fail_count  = 0;
		quiet       = 1'b0;
		hold_done   = 1'b0;
		tx_odds     = 0;

		directed_rows = '{
			// empty line
			'{scrc_pkg::CH_END,    1'b1, scrc_pkg::VERDICT_VALID},
			// redirect right before the end
			'{scrc_pkg::CH_MORE,   1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_END,    1'b1, scrc_pkg::VERDICT_REDIRECT},
			// unclosed single quote
			'{scrc_pkg::CH_SQUOTE, 1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_END,    1'b1, scrc_pkg::VERDICT_QUOTE},
			// redirect inside an unclosed double quote is literal
			'{scrc_pkg::CH_DQUOTE, 1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_MORE,   1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_END,    1'b1, scrc_pkg::VERDICT_QUOTE},
			// triple redirect, then an open quote: the quote wins
			'{scrc_pkg::CH_LESS,   1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_LESS,   1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_LESS,   1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_DQUOTE, 1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_END,    1'b1, scrc_pkg::VERDICT_QUOTE},
			// mixed pair is fine, top-bit byte clears it
			'{scrc_pkg::CH_LESS,   1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_MORE,   1'b0, scrc_pkg::VERDICT_VALID},
			'{8'h80,               1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_END,    1'b0, scrc_pkg::VERDICT_VALID},
			// redirect, space, redirect; fault stays through later text
			'{scrc_pkg::CH_MORE,   1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_SPACE,  1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_MORE,   1'b0, scrc_pkg::VERDICT_VALID},
			'{8'hFF,               1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_END,    1'b0, scrc_pkg::VERDICT_VALID},
			// double quote is literal inside single quotes
			'{scrc_pkg::CH_SQUOTE, 1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_DQUOTE, 1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_SQUOTE, 1'b0, scrc_pkg::VERDICT_VALID},
			'{scrc_pkg::CH_END,    1'b0, scrc_pkg::VERDICT_VALID}
		};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].verdict);

		while (bytes_sent < BYTE_TARGET) begin
			build_line();
			tx_odds = $urandom_range(0, 2) * 3;
			foreach (line_buf[i])
				send_byte(line_buf[i], 1'b0, scrc_pkg::VERDICT_VALID);
		end
		s_tvalid <= 1'b0;

		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
sv/scrc_pkg.sv
sv/scrc_core.sv
sv/shell_quote_redirect_checker.sv
dv/tb_shell_quote_redirect_checker.sv
